/* rtl/svoe_pkg.sv */
// Shared types, constants and phase helpers for the synth voice oscillator/envelope block.
package svoe_pkg;

	// Phase accumulator resolution (fraction bits of one turn)
	localparam int PHASE_BITS = 24;

	// Envelope and waveform constants
	localparam logic [23:0] ENV_FULL   = 24'd8388608;
	localparam logic [23:0] ENV_SILENT = 24'd839;
	localparam logic [16:0] COEF_ONE   = 17'd65536;
	localparam logic [15:0] PW_MIN     = 16'd3277;
	localparam logic [15:0] PW_MAX     = 16'd62259;
	localparam logic [15:0] SUB_MAX    = 16'd32768;
	localparam logic [16:0] VEL_MAX    = 17'd65536;

	// Triangle divider: one quotient bit per cycle
	localparam int DIV_STEPS = 17;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	localparam logic [1:0] CFG_ATTACK  = 2'd0;
	localparam logic [1:0] CFG_RELEASE = 2'd1;
	localparam logic [1:0] CFG_PW      = 2'd2;
	localparam logic [1:0] CFG_SUB     = 2'd3;

	typedef enum logic [1:0] {
		KIND_TICK     = 2'd0,
		KIND_NOTE_ON  = 2'd1,
		KIND_NOTE_OFF = 2'd2,
		KIND_UNUSED   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [6:0]  note;
		logic [16:0] velocity;
		logic [22:0] phase_step;
	} cmd_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  index;
		logic [16:0] data;
	} cfg_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENV_MUL,
		ST_ENV_APPLY,
		ST_GAIN_MUL,
		ST_DIV,
		ST_RESULT
	} state_t;

	// Rescale a Q0.24 increment to PHASE_BITS fraction bits
	function automatic logic [PHASE_BITS-1:0] scale_inc(input logic [23:0] inc24);
		logic [55:0] t;
		t = {inc24, 32'd0} >> (56 - PHASE_BITS);
		return t[PHASE_BITS-1:0];
	endfunction

	// Top 24 bits of a phase as a Q0.24 fraction
	function automatic logic [23:0] phase_top24(input logic [PHASE_BITS-1:0] ph);
		logic [55:0] t;
		t = (56'(ph) << 24) >> PHASE_BITS;
		return t[23:0];
	endfunction

endpackage

/* rtl/svoe_front.sv */
// Input stage: registers incoming transactions, drops unused kinds, saturates velocity.
module svoe_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      kind,
	input  logic [6:0]      note,
	input  logic [16:0]     velocity,
	input  logic [22:0]     phase_step,
	output logic            push_valid,
	output svoe_pkg::cmd_t  push_data,
	input  logic            push_ready
);
	import svoe_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	logic drop;
	logic consume;
	logic accept;

	// Unused kinds are discarded here and never reach the queue
	assign drop       = (cmd_s1.kind == KIND_UNUSED);
	assign consume    = valid_s1 && (drop || push_ready);
	assign in_stall   = valid_s1 && !(drop || push_ready);
	assign accept     = in_valid && !in_stall;
	assign push_valid = valid_s1 && !drop;
	assign push_data  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload capture with velocity saturation
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.kind       <= kind_t'(kind);
			cmd_s1.note       <= note;
			cmd_s1.velocity   <= (velocity > VEL_MAX) ? VEL_MAX : velocity;
			cmd_s1.phase_step <= phase_step;
		end
	end

endmodule

/* rtl/svoe_fifo.sv */
// Short command queue decoupling the input stage from the voice engine.
module svoe_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  svoe_pkg::cmd_t  push_data,
	output logic            push_ready,
	output logic            pop_valid,
	output svoe_pkg::cmd_t  pop_data,
	input  logic            pop_ready
);
	import svoe_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/svoe_back.sv */
// Voice engine: note state, envelope step, phase accumulators, triangle divider, result register.
module svoe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  svoe_pkg::cfg_wr_t   cfg,
	input  logic                cmd_valid,
	input  svoe_pkg::cmd_t      cmd,
	output logic                cmd_ready,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [17:0]  mixed_sample,
	output logic [23:0]         gain,
	output logic                voice_active
);
	import svoe_pkg::*;

	// Configuration registers
	logic [16:0] attack_q;
	logic [16:0] release_q;
	logic [15:0] pw_q;
	logic [15:0] sub_q;

	// Voice state
	logic                  sounding_q;
	logic [6:0]            held_note_q;
	logic [16:0]           held_vel_q;
	logic [23:0]           env_level_q;
	logic                  env_rising_q;
	logic [PHASE_BITS-1:0] main_phase_q;
	logic [PHASE_BITS-1:0] half_phase_q;
	logic [22:0]           note_inc_q;

	// Sequencer and datapath registers
	state_t               state_q, state_d;
	logic                 env_up_q;
	logic [39:0]          prod_q;
	logic [40:0]          rem_q;
	logic [39:0]          dsh_q;
	logic [16:0]          quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 falling_q;
	logic                 sub_neg_q;
	logic                 silent_q;

	// Output register
	logic               out_valid_q;
	logic signed [17:0] mixed_q;
	logic [23:0]        gain_q;
	logic               active_q;

	logic               env_up;
	logic [16:0]        coef_raw;
	logic [16:0]        coef;
	logic [23:0]        env_dist;
	logic [23:0]        move;
	logic [23:0]        lvl_new;
	logic               go_silent;
	logic [15:0]        pw_c;
	logic [23:0]        w;
	logic [23:0]        p;
	logic [23:0]        half_top;
	logic [23:0]        den_fall;
	logic [40:0]        num_rise;
	logic [40:0]        num_fall;
	logic [15:0]        sl;
	logic               ge;
	logic signed [17:0] tri_v;
	logic signed [17:0] sub_v;
	logic signed [17:0] mixed_v;
	logic [23:0]        gain_v;
	logic               out_load;

	// Envelope step terms
	assign env_up   = env_rising_q && (env_level_q < ENV_FULL);
	assign coef_raw = env_up ? attack_q : release_q;
	assign coef     = (coef_raw > COEF_ONE) ? COEF_ONE : coef_raw;
	assign env_dist = env_up ? (ENV_FULL - env_level_q) : (env_rising_q ? 24'd0 : env_level_q);
	assign move     = 24'((prod_q + 40'd65535) >> 16);
	assign lvl_new  = env_up_q ? (env_level_q + move) : (env_level_q - move);
	assign go_silent = (lvl_new < ENV_SILENT) && !env_rising_q;

	// Triangle divider operands
	assign pw_c     = (pw_q < PW_MIN) ? PW_MIN : ((pw_q > PW_MAX) ? PW_MAX : pw_q);
	assign w        = {pw_c, 8'd0};
	assign p        = phase_top24(main_phase_q);
	assign half_top = phase_top24(half_phase_q);
	assign den_fall = 24'(25'h1000000 - {1'b0, w});
	assign num_rise = {1'b0, p, 16'd0} + {18'd0, w[23:1]};
	assign num_fall = {1'b0, 24'(p - w), 16'd0} + {18'd0, den_fall[23:1]};
	assign ge       = (rem_q >= {1'b0, dsh_q});

	// Result assembly
	assign sl      = (sub_q > SUB_MAX) ? SUB_MAX : sub_q;
	assign tri_v   = falling_q ? (18'sd32768 - $signed({1'b0, quo_q}))
	                           : ($signed({1'b0, quo_q}) - 18'sd32768);
	assign sub_v   = sub_neg_q ? -$signed({2'b00, sl}) : $signed({2'b00, sl});
	assign mixed_v = tri_v + sub_v;
	assign gain_v  = 24'((prod_q + 40'd32768) >> 16);

	assign out_load     = (state_q == ST_RESULT) && (!out_valid_q || !out_stall);
	assign cmd_ready    = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign mixed_sample = mixed_q;
	assign gain         = gain_q;
	assign voice_active = active_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && (cmd.kind == KIND_TICK)) begin
					state_d = ST_ENV_MUL;
				end
			end
			ST_ENV_MUL: begin
				state_d = sounding_q ? ST_ENV_APPLY : ST_RESULT;
			end
			ST_ENV_APPLY: begin
				state_d = go_silent ? ST_RESULT : ST_GAIN_MUL;
			end
			ST_GAIN_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= COEF_ONE;
			release_q <= COEF_ONE;
			pw_q      <= 16'd32768;
			sub_q     <= 16'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ATTACK:  attack_q  <= cfg.data;
				CFG_RELEASE: release_q <= cfg.data;
				CFG_PW:      pw_q      <= cfg.data[15:0];
				CFG_SUB:     sub_q     <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// Voice state and sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sounding_q   <= 1'b0;
			held_note_q  <= '0;
			held_vel_q   <= '0;
			env_level_q  <= '0;
			env_rising_q <= 1'b0;
			main_phase_q <= '0;
			half_phase_q <= '0;
			note_inc_q   <= '0;
			silent_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							KIND_NOTE_ON: begin
								sounding_q   <= 1'b1;
								held_note_q  <= cmd.note;
								held_vel_q   <= cmd.velocity;
								env_level_q  <= '0;
								env_rising_q <= 1'b1;
								main_phase_q <= '0;
								half_phase_q <= '0;
								note_inc_q   <= cmd.phase_step;
							end
							KIND_NOTE_OFF: begin
								if (sounding_q && (cmd.note == held_note_q)) begin
									env_rising_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_ENV_MUL: begin
					silent_q <= !sounding_q;
				end
				ST_ENV_APPLY: begin
					env_level_q <= lvl_new;
					if (go_silent) begin
						sounding_q <= 1'b0;
						silent_q   <= 1'b1;
					end else begin
						main_phase_q <= main_phase_q + scale_inc({1'b0, note_inc_q});
						half_phase_q <= half_phase_q + scale_inc({2'b00, note_inc_q[22:1]});
					end
				end
				default: ;
			endcase
		end
	end

	// Multiplier and restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		case (state_q)
			ST_ENV_MUL: begin
				prod_q   <= 40'(env_dist) * 40'(coef);
				env_up_q <= env_up;
			end
			ST_GAIN_MUL: begin
				prod_q    <= 40'(env_level_q) * 40'(held_vel_q);
				falling_q <= !(p < w);
				rem_q     <= (p < w) ? num_rise : num_fall;
				dsh_q     <= (p < w) ? {w, 16'd0} : {den_fall, 16'd0};
				quo_q     <= '0;
				cnt_q     <= DIV_CNT_W'(DIV_STEPS - 1);
				sub_neg_q <= half_top[23];
			end
			ST_DIV: begin
				if (ge) begin
					rem_q <= rem_q - {1'b0, dsh_q};
				end
				quo_q <= {quo_q[15:0], ge};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mixed_q  <= silent_q ? 18'sd0 : mixed_v;
			gain_q   <= silent_q ? 24'd0 : gain_v;
			active_q <= !silent_q;
		end
	end

`ifndef SYNTHESIS
	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_level_q <= ENV_FULL)
		else $error("envelope level above full scale");

	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !active_q) |-> (mixed_q == 18'sd0 && gain_q == 24'd0))
		else $error("inactive result carries nonzero payload");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= DIV_CNT_W'(DIV_STEPS - 1)))
		else $error("divider step count out of range");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && !silent_q) |-> (quo_q <= 17'd65536))
		else $error("triangle quotient exceeds full scale");
`endif

endmodule

/* rtl/synth_voice_osc_envelope.sv */
// Top level of the synth voice: input stage, command queue and voice engine.
// A sounding tick passes the input register, the queue and the engine states idle (queue pop),
// envelope multiply and apply, gain multiply, triangle divider, result, then the output register.
// The engine takes a command only when idle; a sounding tick holds it busy until its result loads.
// Input is accepted while the engine works, until the two-entry queue and input stage fill.
// Reset (arst_n low, asynchronous) silences the voice, empties the queue and
// restores register defaults; no clearing pass is needed.
module synth_voice_osc_envelope (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [6:0]         note,
	input  logic [16:0]        velocity,
	input  logic [22:0]        phase_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] mixed_sample,
	output logic [23:0]        gain,
	output logic               voice_active,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data
);
	import svoe_pkg::*;

	cmd_t    push_data;
	cmd_t    pop_data;
	logic    push_valid;
	logic    push_ready;
	logic    pop_valid;
	logic    pop_ready;
	cfg_wr_t cfg;

	// Register writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	svoe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.note       (note),
		.velocity   (velocity),
		.phase_step (phase_step),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	svoe_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	svoe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd_valid    (pop_valid),
		.cmd          (pop_data),
		.cmd_ready    (pop_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mixed_sample (mixed_sample),
		.gain         (gain),
		.voice_active (voice_active)
	);

endmodule
